// ===== design/cau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Types, codes, widths and saturation helper shared by the unit's modules.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int FRAC_BITS = 16;
   localparam int Q_W       = 32;
   localparam int P_W       = 2 * Q_W;
   localparam int S_W       = P_W + 1;
   localparam int DIV_CELLS = Q_W;

   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
   localparam logic signed [S_W-1:0] S_MAX = S_W'(Q_MAX);
   localparam logic signed [S_W-1:0] S_MIN = S_W'(Q_MIN);

   typedef enum logic [2:0] {
      MODE_ADD  = 3'd0,
      MODE_SUB  = 3'd1,
      MODE_MUL  = 3'd2,
      MODE_DIV  = 3'd3,
      MODE_CONJ = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK  = 2'd0,
      STAT_OVF = 2'd1,
      STAT_DZ  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [Q_W-1:0] val;
      logic                  ovf;
   } sat_type;

   typedef struct packed {
      logic signed [P_W-1:0] rr;
      logic signed [P_W-1:0] ii;
      logic signed [P_W-1:0] ir;
      logic signed [P_W-1:0] ri;
      logic signed [P_W-1:0] brr;
      logic signed [P_W-1:0] bii;
   } prod_type;

   typedef struct packed {
      mode_type              mode;
      logic signed [Q_W-1:0] re;
      logic signed [Q_W-1:0] im;
      logic                  ovf;
      logic                  dz;
      logic                  neg_re;
      logic                  neg_im;
      logic                  big_re;
      logic                  big_im;
      logic [P_W-1:0]        den;
   } side_type;

   typedef struct packed {
      logic [P_W-1:0] rem;
      logic [Q_W-1:0] dq;
   } lane_type;

   function automatic sat_type sat_q(input logic signed [S_W-1:0] v);
      sat_type r;
      r.val = v[Q_W-1:0];
      r.ovf = 1'b0;
      if (v > S_MAX) begin
         r.val = Q_MAX;
         r.ovf = 1'b1;
      end else if (v < S_MIN) begin
         r.val = Q_MIN;
         r.ovf = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== design/cau_mul_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit input stage
// Registers the six operand products and the add, subtract and conjugate results.
// ----------------------------------------------------------------------------
module cau_mul_stage import cau_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  logic [2:0]            up_mode,
   input  logic signed [Q_W-1:0] up_a_re,
   input  logic signed [Q_W-1:0] up_a_im,
   input  logic signed [Q_W-1:0] up_b_re,
   input  logic signed [Q_W-1:0] up_b_im,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output prod_type              dn_prod,
   output side_type              dn_side
);

   logic                valid_ff;
   prod_type            prod_ff, prod_in;
   side_type            side_ff, side_in;
   logic signed [Q_W:0] add_re, add_im, sub_re, sub_im, neg_im;
   sat_type             sr, si;

   assign add_re = {up_a_re[Q_W-1], up_a_re} + {up_b_re[Q_W-1], up_b_re};
   assign add_im = {up_a_im[Q_W-1], up_a_im} + {up_b_im[Q_W-1], up_b_im};
   assign sub_re = {up_a_re[Q_W-1], up_a_re} - {up_b_re[Q_W-1], up_b_re};
   assign sub_im = {up_a_im[Q_W-1], up_a_im} - {up_b_im[Q_W-1], up_b_im};
   assign neg_im = {(Q_W+1){1'b0}} - {up_a_im[Q_W-1], up_a_im};

   always_comb begin
      prod_in.rr  = up_a_re * up_b_re;
      prod_in.ii  = up_a_im * up_b_im;
      prod_in.ir  = up_a_im * up_b_re;
      prod_in.ri  = up_a_re * up_b_im;
      prod_in.brr = up_b_re * up_b_re;
      prod_in.bii = up_b_im * up_b_im;
   end

   always_comb begin
      unique case (mode_type'(up_mode))
         MODE_ADD: begin
            sr = sat_q(S_W'(add_re));
            si = sat_q(S_W'(add_im));
         end
         MODE_SUB: begin
            sr = sat_q(S_W'(sub_re));
            si = sat_q(S_W'(sub_im));
         end
         MODE_CONJ: begin
            sr.val = up_a_re;
            sr.ovf = 1'b0;
            si     = sat_q(S_W'(neg_im));
         end
         default: begin
            sr = '0;
            si = '0;
         end
      endcase
   end

   always_comb begin
      side_in      = '0;
      side_in.mode = mode_type'(up_mode);
      side_in.re   = sr.val;
      side_in.im   = si.val;
      side_in.ovf  = sr.ovf | si.ovf;
      side_in.dz   = (up_b_re == '0) && (up_b_im == '0);
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         prod_ff <= prod_in;
         side_ff <= side_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_prod  = prod_ff;
   assign dn_side  = side_ff;

endmodule

// ===== design/cau_prep_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit preparation stages
// Sums products, finishes multiply, and sets up divider magnitudes and checks.
// ----------------------------------------------------------------------------
module cau_prep_stage import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     up_valid,
   output logic     up_ready,
   input  prod_type up_prod,
   input  side_type up_side,
   output logic     dn_valid,
   input  logic     dn_ready,
   output side_type dn_side,
   output lane_type dn_lane_re,
   output lane_type dn_lane_im
);

   logic                  a_valid_ff, b_valid_ff, a_ready;
   side_type              a_side_ff, a_side_in, b_side_ff, b_side_in;
   logic signed [S_W-1:0] m_re, m_im, nre_in, nim_in, a_nre_ff, a_nim_ff;
   sat_type               mr, mi;
   logic [P_W-1:0]        mag_re, mag_im, r0_re, r0_im;
   lane_type              b_lre_ff, b_lim_ff, lre_in, lim_in;

   // stage a: sums and multiply result
   assign m_re   = S_W'(up_prod.rr) - S_W'(up_prod.ii);
   assign m_im   = S_W'(up_prod.ir) + S_W'(up_prod.ri);
   assign nre_in = S_W'(up_prod.rr) + S_W'(up_prod.ii);
   assign nim_in = S_W'(up_prod.ir) - S_W'(up_prod.ri);
   assign mr     = sat_q(m_re >>> FRAC_BITS);
   assign mi     = sat_q(m_im >>> FRAC_BITS);

   always_comb begin
      a_side_in     = up_side;
      a_side_in.den = $unsigned(up_prod.brr) + $unsigned(up_prod.bii);
      if (up_side.mode == MODE_MUL) begin
         a_side_in.re  = mr.val;
         a_side_in.im  = mi.val;
         a_side_in.ovf = mr.ovf | mi.ovf;
      end
   end

   assign up_ready = !a_valid_ff || a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (up_ready) begin
         a_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         a_side_ff <= a_side_in;
         a_nre_ff  <= nre_in;
         a_nim_ff  <= nim_in;
      end
   end

   // stage b: magnitudes and quotient range check
   assign mag_re = a_nre_ff[S_W-1] ? P_W'(-a_nre_ff) : a_nre_ff[P_W-1:0];
   assign mag_im = a_nim_ff[S_W-1] ? P_W'(-a_nim_ff) : a_nim_ff[P_W-1:0];
   assign r0_re  = mag_re >> (Q_W - FRAC_BITS);
   assign r0_im  = mag_im >> (Q_W - FRAC_BITS);

   always_comb begin
      b_side_in        = a_side_ff;
      b_side_in.neg_re = a_nre_ff[S_W-1];
      b_side_in.neg_im = a_nim_ff[S_W-1];
      b_side_in.big_re = r0_re >= a_side_ff.den;
      b_side_in.big_im = r0_im >= a_side_ff.den;
      lre_in.rem       = r0_re;
      lre_in.dq        = mag_re[Q_W-1:0] << FRAC_BITS;
      lim_in.rem       = r0_im;
      lim_in.dq        = mag_im[Q_W-1:0] << FRAC_BITS;
   end

   assign a_ready = !b_valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && a_ready) begin
         b_side_ff <= b_side_in;
         b_lre_ff  <= lre_in;
         b_lim_ff  <= lim_in;
      end
   end

   assign dn_valid   = b_valid_ff;
   assign dn_side    = b_side_ff;
   assign dn_lane_re = b_lre_ff;
   assign dn_lane_im = b_lim_ff;

endmodule

// ===== design/cau_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider cell
// One restoring quotient bit for the real and imaginary lanes per cell.
// ----------------------------------------------------------------------------
module cau_div_cell import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     up_valid,
   output logic     up_ready,
   input  side_type up_side,
   input  lane_type up_lane_re,
   input  lane_type up_lane_im,
   output logic     dn_valid,
   input  logic     dn_ready,
   output side_type dn_side,
   output lane_type dn_lane_re,
   output lane_type dn_lane_im
);

   function automatic lane_type div_step(input lane_type l, input logic [P_W-1:0] den);
      logic [P_W:0] trial;
      logic         fit;
      lane_type     r;
      trial = {l.rem, l.dq[Q_W-1]};
      fit   = trial >= {1'b0, den};
      r.rem = fit ? P_W'(trial - {1'b0, den}) : trial[P_W-1:0];
      r.dq  = {l.dq[Q_W-2:0], fit};
      return r;
   endfunction

   logic     valid_ff;
   side_type side_ff;
   lane_type lre_ff, lim_ff;

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         side_ff <= up_side;
         lre_ff  <= div_step(up_lane_re, up_side.den);
         lim_ff  <= div_step(up_lane_im, up_side.den);
      end
   end

   assign dn_valid   = valid_ff;
   assign dn_side    = side_ff;
   assign dn_lane_re = lre_ff;
   assign dn_lane_im = lim_ff;

endmodule

// ===== design/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide and conjugate on signed Q16.16 complex items.
// ----------------------------------------------------------------------------
//   channel   ports                               direction
//   req       valid ready mode a_re a_im b_re b_im   in
//   rsp       valid ready res_re res_im status       out
//
// one item per cycle while rsp_ready is not held low; stages in order: product stage, sum stage,
// magnitude stage, 32 divider cells and the output register
// the row of 32 divider cells, one quotient bit each, sets the latency
// reset clears the valid bits only
// each stage takes a new item when it is empty or its item moves on
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_mode,
   input  logic signed [Q_W-1:0] req_a_re,
   input  logic signed [Q_W-1:0] req_a_im,
   input  logic signed [Q_W-1:0] req_b_re,
   input  logic signed [Q_W-1:0] req_b_im,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [Q_W-1:0] rsp_res_re,
   output logic signed [Q_W-1:0] rsp_res_im,
   output logic [1:0]            rsp_status
);

   function automatic sat_type div_fix(input lane_type l, input logic neg, input logic big);
      sat_type        r;
      logic [Q_W-1:0] q;
      q     = l.dq;
      r.val = '0;
      r.ovf = 1'b0;
      if (big) begin
         r.ovf = 1'b1;
         r.val = neg ? Q_MIN : Q_MAX;
      end else if (neg) begin
         if (q > $unsigned(Q_MIN)) begin
            r.ovf = 1'b1;
            r.val = Q_MIN;
         end else begin
            r.val = -q;
         end
      end else if (q[Q_W-1]) begin
         r.ovf = 1'b1;
         r.val = Q_MAX;
      end else begin
         r.val = q;
      end
      return r;
   endfunction

   logic                  m_valid, m_ready;
   prod_type              m_prod;
   side_type              m_side;
   logic                  c_valid [0:DIV_CELLS];
   logic                  c_ready [0:DIV_CELLS];
   side_type              c_side [0:DIV_CELLS];
   lane_type              c_lre [0:DIV_CELLS];
   lane_type              c_lim [0:DIV_CELLS];
   side_type              o_side;
   sat_type               fr, fi;
   logic                  o_ovf;
   logic                  rsp_valid_ff;
   logic signed [Q_W-1:0] re_ff, re_in, im_ff, im_in;
   status_type            status_ff, status_in;

   cau_mul_stage u_mul (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_mode  (req_mode),
      .up_a_re  (req_a_re),
      .up_a_im  (req_a_im),
      .up_b_re  (req_b_re),
      .up_b_im  (req_b_im),
      .dn_valid (m_valid),
      .dn_ready (m_ready),
      .dn_prod  (m_prod),
      .dn_side  (m_side)
   );

   cau_prep_stage u_prep (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (m_valid),
      .up_ready   (m_ready),
      .up_prod    (m_prod),
      .up_side    (m_side),
      .dn_valid   (c_valid[0]),
      .dn_ready   (c_ready[0]),
      .dn_side    (c_side[0]),
      .dn_lane_re (c_lre[0]),
      .dn_lane_im (c_lim[0])
   );

   for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
      cau_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (c_valid[k]),
         .up_ready   (c_ready[k]),
         .up_side    (c_side[k]),
         .up_lane_re (c_lre[k]),
         .up_lane_im (c_lim[k]),
         .dn_valid   (c_valid[k+1]),
         .dn_ready   (c_ready[k+1]),
         .dn_side    (c_side[k+1]),
         .dn_lane_re (c_lre[k+1]),
         .dn_lane_im (c_lim[k+1])
      );
   end

   assign o_side = c_side[DIV_CELLS];
   assign fr     = div_fix(c_lre[DIV_CELLS], o_side.neg_re, o_side.big_re);
   assign fi     = div_fix(c_lim[DIV_CELLS], o_side.neg_im, o_side.big_im);

   always_comb begin
      re_in = o_side.re;
      im_in = o_side.im;
      o_ovf = o_side.ovf;
      if (o_side.mode == MODE_DIV) begin
         if (o_side.dz) begin
            re_in = '0;
            im_in = '0;
            o_ovf = 1'b0;
         end else begin
            re_in = fr.val;
            im_in = fi.val;
            o_ovf = fr.ovf | fi.ovf;
         end
      end
   end

   always_comb begin
      priority if (o_side.mode == MODE_DIV && o_side.dz) begin
         status_in = STAT_DZ;
      end else if (o_ovf) begin
         status_in = STAT_OVF;
      end else begin
         status_in = STAT_OK;
      end
   end

   assign c_ready[DIV_CELLS] = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c_ready[DIV_CELLS]) begin
         rsp_valid_ff <= c_valid[DIV_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (c_valid[DIV_CELLS] && c_ready[DIV_CELLS]) begin
         re_ff     <= re_in;
         im_ff     <= im_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_res_re = re_ff;
   assign rsp_res_im = im_ff;
   assign rsp_status = status_ff;

`ifndef SYNTHESIS
   a_empty_takes_item: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output register empty");

   a_dz_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_DZ |-> rsp_res_re == '0 && rsp_res_im == '0)
      else $error("divide by zero item with nonzero result");

   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_OVF |->
         (rsp_res_re == Q_MAX || rsp_res_re == Q_MIN ||
          rsp_res_im == Q_MAX || rsp_res_im == Q_MIN))
      else $error("overflow status without a saturated part");
`endif

endmodule
